// File: hdl/wsrf_pkg.sv
// ----------------------------------------------------------------------------
// wsrf_pkg
// shared types, constants and helpers for the windowed success-rate
// failover tracker
// ----------------------------------------------------------------------------
package wsrf_pkg;

  localparam int TIME_BITS  = 48;
  localparam int COUNT_BITS = 32;
  localparam int RATIO_BITS = 18;
  localparam int WLEN_BITS  = 32;
  localparam int MINS_BITS  = 32;
  localparam int LEVEL_BITS = 3;
  localparam int TOTAL_BITS = COUNT_BITS + 1;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUCCESS_RATIO = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SAMPLES   = 2'd2;

  // item kinds
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [LEVEL_BITS-1:0] MAX_LEVEL = 3'd4;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic        op;
    logic        success;
    logic [47:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        switch_trigger;
    logic        window_closed;
    logic [31:0] closed_success_count;
    logic [31:0] closed_failure_count;
    logic [32:0] closed_total_count;
    logic        switch_busy;
    logic [2:0]  backoff_step;
    logic [47:0] next_allowed_ms;
  } out_item_t;

  typedef struct packed {
    logic [WLEN_BITS-1:0]  window_length_ms;
    logic [RATIO_BITS-1:0] success_ratio_q16;
    logic [MINS_BITS-1:0]  min_sample_count;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] ok_count;
    logic [COUNT_BITS-1:0] fail_count;
    logic                  window_open;
    logic [TIME_BITS-1:0]  window_start_ms;
    logic                  switch_pending;
    logic [LEVEL_BITS-1:0] backoff_level;
    logic [TIME_BITS-1:0]  next_switch_ms;
  } track_state_t;

  // verdict on a closed window
  typedef struct packed {
    logic enough;
    logic healthy;
  } verdict_t;

  // backoff delay for a level, already clamped to MAX_LEVEL
  function automatic logic [TIME_BITS-1:0] backoff_ms(input logic [LEVEL_BITS-1:0] lv);
    logic [TIME_BITS-1:0] d;
    case (lv)
      3'd0:    d = TIME_BITS'(1000);
      3'd1:    d = TIME_BITS'(2000);
      3'd2:    d = TIME_BITS'(4000);
      3'd3:    d = TIME_BITS'(8000);
      default: d = TIME_BITS'(10000);
    endcase
    return d;
  endfunction

endpackage

// File: hdl/windowed_success_rate_failover.sv
// ----------------------------------------------------------------------------
// windowed_success_rate_failover
// counts request outcomes in fixed time windows and raises a failover
// trigger when a closed window with enough samples falls below the required success rate
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  cfg     | in        | cfg_we (no wait)      | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready   | in_data  (op, success, now_ms)
//  out     | out       | out_valid / out_ready | out_data (one result per item)
//
// one item per cycle sustained while out_ready is high; each item passes
// through the input register and then the result register
// the tracker state is updated in the same cycle the item moves into the
// result register, so a following item sees it at once
// rst is synchronous and clears state, configuration and both valid flags
// a stalled result holds the result register; the input register still
// takes one more item before in_ready drops
// ----------------------------------------------------------------------------
module windowed_success_rate_failover (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wsrf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [wsrf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  wsrf_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output wsrf_pkg::out_item_t              out_data
);
  import wsrf_pkg::*;

  cfg_t         cfg;
  track_state_t state;
  track_state_t state_next;
  out_item_t    result_next;
  in_item_t     item;
  logic         item_valid;
  logic         advance;

  // item moves into the result register when that register is free
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: cfg.window_length_ms  <= cfg_data[WLEN_BITS-1:0];
        REG_SUCCESS_RATIO: cfg.success_ratio_q16 <= cfg_data[RATIO_BITS-1:0];
        REG_MIN_SAMPLES:   cfg.min_sample_count  <= cfg_data[MINS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  wsrf_step u_step (
    .item (item),
    .cfg  (cfg),
    .cur  (state),
    .nxt  (state_next),
    .res  (result_next)
  );

  // tracker state follows each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_next;
    end
  end

  // backoff level never passes its ceiling
  a_level_cap: assert property (@(posedge clk) disable iff (rst)
    state.backoff_level <= MAX_LEVEL)
    else $error("backoff level above ceiling");

  // a trigger only comes with a closed window and a busy switch
  a_trigger_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.switch_trigger |-> out_data.window_closed && out_data.switch_busy)
    else $error("trigger without close or busy flag");

  // closed total is the sum of the closed counts
  a_total_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.closed_total_count ==
      ({1'b0, out_data.closed_success_count} + {1'b0, out_data.closed_failure_count}))
    else $error("closed total mismatch");

  // a processed finish always ends a pending switch
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item.op == OP_FINISH |=> !state.switch_pending)
    else $error("switch still pending after finish");

  // a result shown is the state left after its item
  a_result_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_data.switch_busy == state.switch_pending &&
                out_data.backoff_step == state.backoff_level)
    else $error("result does not match tracker state");

endmodule

// File: hdl/wsrf_judge.sv
// ----------------------------------------------------------------------------
// wsrf_judge
// sample-count check and success-rate compare of a closed window
// ----------------------------------------------------------------------------
module wsrf_judge (
  input  logic [wsrf_pkg::COUNT_BITS-1:0] ok_count,
  input  logic [wsrf_pkg::COUNT_BITS-1:0] fail_count,
  input  wsrf_pkg::cfg_t                  cfg,
  output logic [wsrf_pkg::TOTAL_BITS-1:0] total,
  output wsrf_pkg::verdict_t              verdict
);
  import wsrf_pkg::*;

  localparam int PROD_BITS = TOTAL_BITS + RATIO_BITS;

  logic [PROD_BITS-1:0] need;
  logic [PROD_BITS-1:0] have;

  assign total = {1'b0, ok_count} + {1'b0, fail_count};

  // ok * 1.0 against total * ratio, both exact
  assign need = PROD_BITS'(total) * PROD_BITS'(cfg.success_ratio_q16);
  assign have = PROD_BITS'({ok_count, {FRAC_BITS{1'b0}}});

  assign verdict.enough  = total >= TOTAL_BITS'(cfg.min_sample_count);
  assign verdict.healthy = have >= need;

endmodule

// File: hdl/wsrf_step.sv
// ----------------------------------------------------------------------------
// wsrf_step
// next tracker state and result for one item
// ----------------------------------------------------------------------------
module wsrf_step (
  input  wsrf_pkg::in_item_t     item,
  input  wsrf_pkg::cfg_t         cfg,
  input  wsrf_pkg::track_state_t cur,
  output wsrf_pkg::track_state_t nxt,
  output wsrf_pkg::out_item_t    res
);
  import wsrf_pkg::*;

  logic [TOTAL_BITS-1:0] total;
  verdict_t              verdict;
  logic [LEVEL_BITS-1:0] lv;
  logic [TIME_BITS-1:0]  age;
  logic                  disabled;
  logic                  ok_inc;
  logic                  fail_inc;

  wsrf_judge u_judge (
    .ok_count   (cur.ok_count),
    .fail_count (cur.fail_count),
    .cfg        (cfg),
    .total      (total),
    .verdict    (verdict)
  );

  assign lv       = (cur.backoff_level > MAX_LEVEL) ? MAX_LEVEL : cur.backoff_level;
  assign age      = item.now_ms - cur.window_start_ms;
  assign disabled = (cfg.success_ratio_q16 == '0) || (cfg.window_length_ms == '0);
  assign ok_inc   = (cur.ok_count != COUNT_MAX);
  assign fail_inc = (cur.fail_count != COUNT_MAX);

  always_comb begin
    nxt = cur;
    res = '0;
    if (item.op == OP_FINISH) begin
      if (!item.success) begin
        nxt.next_switch_ms = item.now_ms + backoff_ms(lv);
        nxt.backoff_level  = (lv == MAX_LEVEL) ? MAX_LEVEL : lv + 3'd1;
      end
      nxt.switch_pending = 1'b0;
    end else if (disabled) begin
      nxt = '0;
    end else if (!cur.window_open || (age < TIME_BITS'(cfg.window_length_ms))) begin
      if (!cur.window_open) begin
        nxt.window_open     = 1'b1;
        nxt.window_start_ms = item.now_ms;
      end
      if (item.success) begin
        if (ok_inc) nxt.ok_count = cur.ok_count + COUNT_BITS'(1);
      end else begin
        if (fail_inc) nxt.fail_count = cur.fail_count + COUNT_BITS'(1);
      end
    end else begin
      // close: report old counts, new window holds this record
      nxt.window_start_ms      = item.now_ms;
      nxt.ok_count             = COUNT_BITS'(item.success);
      nxt.fail_count           = COUNT_BITS'(!item.success);
      res.window_closed        = 1'b1;
      res.closed_success_count = cur.ok_count;
      res.closed_failure_count = cur.fail_count;
      res.closed_total_count   = total;
      if (verdict.enough) begin
        if (verdict.healthy) begin
          nxt.backoff_level  = '0;
          nxt.next_switch_ms = '0;
        end else if ((item.now_ms >= cur.next_switch_ms) && !cur.switch_pending) begin
          nxt.switch_pending = 1'b1;
          res.switch_trigger = 1'b1;
        end
      end
    end
    res.switch_busy     = nxt.switch_pending;
    res.backoff_step    = nxt.backoff_level;
    res.next_allowed_ms = nxt.next_switch_ms;
  end

endmodule
